>>> design/espa_pkg.sv
// Package for the eased scale pulse animator.
// Holds op codes, register indexes and fixed-point constants; no dependencies.
package espa_pkg;
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [2:0] REG_INITIAL    = 3'd0;
  localparam logic [2:0] REG_STEP       = 3'd1;
  localparam logic [2:0] REG_MAXIMUM    = 3'd2;
  localparam logic [2:0] REG_HOLD       = 3'd3;
  localparam logic [2:0] REG_TRANSITION = 3'd4;

  localparam logic [15:0] ONE_Q12 = 16'd4096;
  localparam logic [16:0] ONE_P16 = 17'd65536;
endpackage

>>> design/espa_divider.sv
// Restoring bit-serial divider for progress: floor(d * 65536 / t), d < t.
// One quotient bit per cycle; uses espa_pkg.
module espa_divider
  import espa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] quotient
);
  logic [16:0] rem;
  logic [4:0]  count;
  logic [16:0] trial;

  always_comb begin
    trial = {rem[15:0], 1'b0} - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= 5'd16;
      rem      <= {1'b0, dividend};
      quotient <= '0;
    end else if (busy) begin
      if (!trial[16]) begin
        rem      <= trial;
        quotient <= {quotient[14:0], 1'b1};
      end else begin
        rem      <= {rem[15:0], 1'b0};
        quotient <= {quotient[14:0], 1'b0};
      end
      count <= count - 5'd1;
      if (count == 5'd1) busy <= 1'b0;
    end
  end
endmodule

>>> design/espa_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, 34 x 17 unsigned.
// Product is 51 bits; uses espa_pkg.
module espa_serial_mul
  import espa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] a,
  input  logic [16:0] b,
  output logic        busy,
  output logic [50:0] product
);
  logic [16:0] mplier;
  logic [50:0] mcand;
  logic [4:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      count   <= 5'd17;
      mplier  <= b;
      mcand   <= {17'd0, a};
      product <= '0;
    end else if (busy) begin
      if (mplier[0]) product <= product + mcand;
      mplier <= mplier >> 1;
      mcand  <= mcand << 1;
      count  <= count - 5'd1;
      if (count == 5'd1) busy <= 1'b0;
    end
  end
endmodule

>>> design/eased_scale_pulse_animator_unit.sv
// Eased scale pulse animator, top level: handshake, sequencer, state.
// Instantiates espa_divider and espa_serial_mul; uses espa_pkg.
//
// One item is in work at a time. A clear, a trigger, an idle tick or an unused
// code passes through DECODE and OUT before its result is shown; a running tick
// also goes through the bit-serial divider (one quotient bit a cycle) when the
// progress is fractional, and through three passes of the shared shift-add
// multiplier for the square, the cube and the blend. The result is held on the
// output until it is transferred; the next item is taken after that.
module eased_scale_pulse_animator_unit
  import espa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // op[1:0], now[33:2], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // scale[15:0], target[31:16], is_active[32],
                                 // is_finished[33], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [3:0] {
    IDLE, DECODE, DIV, DIV_WAIT, SQ, SQ_WAIT, CUBE, CUBE_WAIT, BLEND, BLEND_WAIT, OUT
  } state_t;

  state_t state;
  logic [15:0] initial_scale, scale_step, maximum_scale, hold_time, transition_time;
  logic        running, done;
  logic [15:0] current_scale, target_scale, start_scale;
  logic [31:0] start_time, decay_time;
  logic [1:0]  op;
  logic [31:0] now;
  logic [16:0] prog;
  logic        upper;
  logic [16:0] base;
  logic [16:0] ease;
  logic [33:0] sq;
  logic        neg;

  logic        div_start, div_busy, mul_start, mul_busy;
  logic [15:0] div_q;
  logic [33:0] mul_a;
  logic [16:0] mul_b;
  logic [50:0] mul_p;

  logic [31:0] d_elapsed, d_decay;
  logic [15:0] eff_max;
  logic [16:0] goal_wide;
  logic [15:0] goal;
  logic [16:0] diff_abs;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == IDLE) && !m_tvalid;
  assign m_tdata   = {6'd0, done, running, target_scale, current_scale};

  assign d_elapsed = now - start_time;
  assign d_decay   = now - decay_time;
  assign eff_max   = (maximum_scale < ONE_Q12) ? ONE_Q12 : maximum_scale;
  assign diff_abs  = (target_scale >= start_scale) ?
                     {1'b0, target_scale - start_scale} : {1'b0, start_scale - target_scale};

  always_comb begin
    if (target_scale <= ONE_Q12 || !running) goal_wide = {1'b0, initial_scale};
    else goal_wide = {1'b0, target_scale} + {1'b0, scale_step};
    if (goal_wide > {1'b0, eff_max}) goal = eff_max;
    else if (goal_wide < {1'b0, ONE_Q12}) goal = ONE_Q12;
    else goal = goal_wide[15:0];
  end

  assign div_start = (state == DIV);
  assign mul_start = (state == SQ) || (state == CUBE) || (state == BLEND);

  always_comb begin
    unique case (state)
      SQ:      begin mul_a = {17'd0, base};     mul_b = base; end
      CUBE:    begin mul_a = sq;                mul_b = base; end
      BLEND:   begin mul_a = {17'd0, diff_abs}; mul_b = ease; end
      default: begin mul_a = '0;                mul_b = '0;   end
    endcase
  end

  espa_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(d_elapsed[15:0]), .divisor(transition_time),
    .busy(div_busy), .quotient(div_q)
  );

  espa_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .product(mul_p)
  );

  logic [33:0] blend_acc;
  always_comb begin
    if (neg) blend_acc = {2'd0, start_scale, 16'h8000} - mul_p[33:0];
    else     blend_acc = {2'd0, start_scale, 16'h8000} + mul_p[33:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      m_tvalid        <= 1'b0;
      initial_scale   <= 16'd6144;
      scale_step      <= 16'd2048;
      maximum_scale   <= 16'd12288;
      hold_time       <= 16'd500;
      transition_time <= 16'd150;
      running         <= 1'b0;
      done            <= 1'b0;
      current_scale   <= ONE_Q12;
      target_scale    <= ONE_Q12;
      start_scale     <= ONE_Q12;
      start_time      <= '0;
      decay_time      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_INITIAL:    initial_scale   <= cfg_data;
          REG_STEP:       scale_step      <= cfg_data;
          REG_MAXIMUM:    maximum_scale   <= cfg_data;
          REG_HOLD:       hold_time       <= cfg_data;
          REG_TRANSITION: transition_time <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: if (s_tvalid && s_tready) begin
          op    <= s_tdata[1:0];
          now   <= s_tdata[33:2];
          state <= DECODE;
        end
        DECODE: begin
          if (op == OP_TRIGGER) begin
            if (!running) begin
              running       <= 1'b1;
              done          <= 1'b0;
              current_scale <= ONE_Q12;
              start_scale   <= ONE_Q12;
            end else begin
              start_scale <= current_scale;
            end
            target_scale <= goal;
            start_time   <= now;
            decay_time   <= now + {16'd0, hold_time};
            state        <= OUT;
          end else if (op == OP_CLEAR) begin
            current_scale <= ONE_Q12;
            target_scale  <= ONE_Q12;
            start_scale   <= ONE_Q12;
            running       <= 1'b0;
            done          <= 1'b0;
            state         <= OUT;
          end else if (op == OP_TICK && running) begin
            if (!d_decay[31] && target_scale != ONE_Q12) begin
              start_scale  <= current_scale;
              target_scale <= ONE_Q12;
              start_time   <= now;
              prog         <= (transition_time == 16'd0) ? ONE_P16 : 17'd0;
              state        <= SQ;
            end else if (transition_time == 16'd0) begin
              prog  <= ONE_P16;
              state <= SQ;
            end else if (d_elapsed[31] || d_elapsed == 32'd0) begin
              prog  <= 17'd0;
              state <= SQ;
            end else if (d_elapsed >= {16'd0, transition_time}) begin
              prog  <= ONE_P16;
              state <= SQ;
            end else begin
              state <= DIV;
            end
          end else begin
            state <= OUT;
          end
        end
        DIV: state <= DIV_WAIT;
        DIV_WAIT: if (!div_busy) begin
          prog  <= {1'b0, div_q};
          state <= SQ;
        end
        SQ: state <= SQ_WAIT;
        SQ_WAIT: if (!mul_busy) begin
          sq    <= mul_p[33:0];
          state <= CUBE;
        end
        CUBE: state <= CUBE_WAIT;
        CUBE_WAIT: if (!mul_busy) begin
          if (upper) ease <= ONE_P16 - {1'b0, mul_p[48:33]};
          else       ease <= {2'd0, mul_p[44:30]};
          neg   <= target_scale < start_scale;
          state <= BLEND;
        end
        BLEND: state <= BLEND_WAIT;
        BLEND_WAIT: if (!mul_busy) begin
          current_scale <= blend_acc[31:16];
          if (prog == ONE_P16 && target_scale == ONE_Q12) begin
            running <= 1'b0;
            done    <= 1'b1;
          end
          state <= OUT;
        end
        OUT: begin
          m_tvalid <= 1'b1;
          state    <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Cube p^3 (scaled 2^-30) below one half, else s^3 with s = 2(1-p) (scaled 2^-33).
  always_comb begin
    upper = prog >= 17'd32768;
    base  = upper ? ((ONE_P16 - prog) << 1) : prog;
  end
endmodule
